FILE: sv/hcle_pkg.sv
// hcle_pkg: types and constants for the content-length header extractor
// transaction structs, per-line parse state and the header name table
// no dependencies
package hcle_pkg;

  localparam int unsigned NameLen  = 14;
  localparam int unsigned NameIdxW = 4;
  localparam int unsigned ValueW   = 64;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_PLUS,
    SIGN_MINUS,
    SIGN_UNSIGNED
  } sign_e;

  typedef enum logic [1:0] {
    DIG_NONE,
    DIG_IN,
    DIG_DONE,
    DIG_EMPTY
  } digit_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [ValueW-1:0] length_value;
  } out_t;

  typedef struct packed {
    logic [NameIdxW-1:0] name_idx;
    logic                mismatch;
    logic                colon;
    sign_e               sign;
    digit_e              digit;
    logic [ValueW-1:0]   acc;
    logic                ovf;
  } line_t;

  localparam line_t LineReset = '{
    name_idx: '0,
    mismatch: 1'b0,
    colon:    1'b0,
    sign:     SIGN_NONE,
    digit:    DIG_NONE,
    acc:      '0,
    ovf:      1'b0
  };

  // expected header name, one character per matched position
  function automatic logic [7:0] name_char(logic [NameIdxW-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h4C; // L
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: sv/http_content_length_extractor.sv
// http_content_length_extractor: finds the Content-Length value in a header block
// input register, one-byte line parser with a x10 multiply-add, result register
// depends on hcle_pkg
//
// usage:
//   the input channel (in_valid_i, in_stall_o, in_i) carries one header byte per
//   transaction, with last_byte marking the final byte of a block. the output
//   channel (out_valid_o, out_stall_i, out_o) carries one transaction per block:
//   found and the 64-bit length value (0 when nothing was found).
//   one byte is taken every cycle while the input is not stalled. a byte is
//   parsed while it sits in the input register, and the result of a block is
//   loaded into the output register as its last byte leaves the parser.
//   the per-byte rate is set by the accumulator update, one multiply by ten
//   and add per cycle, which carries state from each byte to the next.
//   while a result waits on a stalled receiver, ordinary bytes keep flowing;
//   the input stalls only when another last byte reaches the parser before the
//   waiting result is taken.
//   reset empties both registers and clears all parse state.
module http_content_length_extractor
  import hcle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic              s1_valid_q, s1_valid_d;
  in_t               s1_q;
  logic              have_q, have_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic              neg_q, neg_d;
  logic              cr_q, cr_d;
  line_t             line_q, line_d;
  logic              out_valid_q, out_valid_d;
  logic              out_found_q;
  logic [ValueW-1:0] out_mag_q;
  logic              out_neg_q;

  logic              in_accept, advance, produce, out_take;
  logic [7:0]        ch;
  logic              is_ws, is_digit, crlf, finishing, eval_ok;
  logic [ValueW+3:0] prod;
  line_t             lc, eval_line;
  logic              new_have;
  logic [ValueW-1:0] new_mag;
  logic              new_neg;

  // handshake
  assign out_take    = out_valid_q && !out_stall_i;
  assign advance     = s1_valid_q && !(s1_q.last_byte && out_valid_q && out_stall_i);
  assign produce     = advance && s1_q.last_byte;
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !advance);
  assign out_valid_d = produce || (out_valid_q && !out_take);

  // byte classification
  assign ch       = s1_q.byte_in;
  assign is_ws    = (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
  assign is_digit = (ch >= ChZero) && (ch <= ChNine);
  assign crlf     = (ch == ChLf) && cr_q;
  assign prod     = {1'b0, line_q.acc, 3'b000} + {3'b000, line_q.acc, 1'b0}
                  + {{(ValueW){1'b0}}, ch[3:0]};

  // line state after one non-whitespace character
  always_comb begin
    lc = line_q;
    if (!line_q.colon) begin
      if (ch == ChColon) begin
        lc.colon = 1'b1;
        if (line_q.name_idx != NameIdxW'(NameLen)) begin
          lc.mismatch = 1'b1;
        end
      end else if (!line_q.mismatch) begin
        if ((line_q.name_idx < NameIdxW'(NameLen)) && (ch == name_char(line_q.name_idx))) begin
          lc.name_idx = line_q.name_idx + 1'b1;
        end else begin
          lc.mismatch = 1'b1;
        end
      end
    end else if (!line_q.mismatch &&
                 ((line_q.digit == DIG_NONE) || (line_q.digit == DIG_IN))) begin
      if (is_digit) begin
        if (!line_q.ovf) begin
          if (prod[ValueW+3:ValueW] != 4'b0000) begin
            lc.ovf = 1'b1;
          end else begin
            lc.acc = prod[ValueW-1:0];
          end
        end
        lc.digit = DIG_IN;
        if (line_q.sign == SIGN_NONE) begin
          lc.sign = SIGN_UNSIGNED;
        end
      end else if ((line_q.sign == SIGN_NONE) && ((ch == ChPlus) || (ch == ChMinus))) begin
        lc.sign = (ch == ChPlus) ? SIGN_PLUS : SIGN_MINUS;
      end else begin
        lc.digit = (line_q.digit == DIG_IN) ? DIG_DONE : DIG_EMPTY;
        if (line_q.sign == SIGN_NONE) begin
          lc.sign = SIGN_UNSIGNED;
        end
      end
    end
  end

  // line end and result update
  always_comb begin
    eval_line = (crlf || is_ws) ? line_q : lc;
    finishing = crlf || s1_q.last_byte;
    eval_ok   = eval_line.colon && !eval_line.mismatch && !eval_line.ovf &&
                ((eval_line.digit == DIG_IN) || (eval_line.digit == DIG_DONE));
    new_have  = have_q || (finishing && eval_ok);
    new_mag   = (finishing && eval_ok) ? eval_line.acc : mag_q;
    new_neg   = (finishing && eval_ok) ? (eval_line.sign == SIGN_MINUS) : neg_q;

    have_d = have_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    cr_d   = cr_q;
    line_d = line_q;
    if (advance) begin
      if (s1_q.last_byte) begin
        have_d = 1'b0;
        mag_d  = '0;
        neg_d  = 1'b0;
        cr_d   = 1'b0;
        line_d = LineReset;
      end else begin
        have_d = new_have;
        mag_d  = new_mag;
        neg_d  = new_neg;
        cr_d   = crlf ? 1'b0 : (ch == ChCr);
        line_d = finishing ? LineReset : eval_line;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      cr_q        <= 1'b0;
      line_q      <= LineReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      have_q      <= have_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      cr_q        <= cr_d;
      line_q      <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= in_i;
    end
    if (produce) begin
      out_found_q <= new_have;
      out_mag_q   <= new_have ? new_mag : '0;
      out_neg_q   <= new_have && new_neg;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_o.found        = out_found_q;
  assign out_o.length_value = out_neg_q ? (ValueW'(0) - out_mag_q) : out_mag_q;

  a_plain_byte_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_q.last_byte) |-> !in_stall_o)
    else $error("input stalled on a byte that is not last");

  a_clear_after_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce |=> (!have_q && !cr_q && !line_q.colon && (line_q.name_idx == '0)))
    else $error("parse state not cleared after a block");

  a_empty_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_q |-> ((mag_q == '0) && !neg_q))
    else $error("stored value without a found flag");

  a_name_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q.name_idx <= NameIdxW'(NameLen))
    else $error("name index past the header name");

endmodule

FILE: tb/http_content_length_extractor_tb.sv
// http_content_length_extractor_tb: self-checking bench for the content-length extractor
// random header blocks drive the byte channel, a local parser predicts each block result
// depends on hcle_pkg and http_content_length_extractor
module http_content_length_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcle_pkg::*;

  localparam int unsigned NumItems  = 1550;
  localparam int unsigned CycLimit  = 200000;
  localparam int unsigned HoldCyc   = 300;
  localparam int unsigned QuietLo   = 600;
  localparam int unsigned QuietHi   = 1100;
  localparam int unsigned TailCyc   = 8;
  localparam logic [8*NameLen-1:0] HdrName = "Content-Length";

  typedef struct {
    in_t pl;
    bit  drain;
    bit  rx_hold;
  } pend_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  pend_t        pend_q[$];
  pend_t        cur;
  out_t         len_q[$];
  byte unsigned blk[$];

  int unsigned     cyc          = 0;
  int unsigned     errors       = 0;
  int unsigned     rx_hold_left = 0;
  logic            rx_hold_go   = 1'b0;
  longint unsigned n_total      = 0;
  longint unsigned n_sent       = 0;
  longint unsigned n_expected   = 0;
  longint unsigned n_checked    = 0;
  logic            quiet;

  // parser state of the bench
  logic              have_len = 1'b0;
  logic [ValueW-1:0] len_val  = '0;
  logic              cr_seen  = 1'b0;
  line_t             ln       = LineReset;

  assign quiet = (cyc >= QuietLo) && (cyc < QuietHi);

  http_content_length_extractor u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] hdr_char(int unsigned idx);
    return HdrName[8*(NameLen-1-idx) +: 8];
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void close_line();
    if (ln.colon && !ln.mismatch && (ln.digit == DIG_IN || ln.digit == DIG_DONE) && !ln.ovf) begin
      have_len = 1'b1;
      len_val  = (ln.sign == SIGN_MINUS) ? -ln.acc : ln.acc;
    end
    ln = LineReset;
  endfunction

  function automatic void value_char(logic [7:0] c);
    logic [ValueW-1:0] d;
    if (ln.digit == DIG_NONE || ln.digit == DIG_IN) begin
      if (c >= ChZero && c <= ChNine) begin
        d = ValueW'(c - ChZero);
        if (!ln.ovf) begin
          if (ln.acc > ({ValueW{1'b1}} - d) / 10) begin
            ln.ovf = 1'b1;
          end else begin
            ln.acc = ln.acc * 10 + d;
          end
        end
        ln.digit = DIG_IN;
        if (ln.sign == SIGN_NONE) ln.sign = SIGN_UNSIGNED;
      end else if (ln.sign == SIGN_NONE && (c == ChPlus || c == ChMinus)) begin
        if (c == ChPlus) ln.sign = SIGN_PLUS;
        else ln.sign = SIGN_MINUS;
      end else begin
        if (ln.digit == DIG_IN) ln.digit = DIG_DONE;
        else ln.digit = DIG_EMPTY;
        if (ln.sign == SIGN_NONE) ln.sign = SIGN_UNSIGNED;
      end
    end
  endfunction

  function automatic void line_char(logic [7:0] c);
    if (!ln.colon) begin
      if (c == ChColon) begin
        ln.colon = 1'b1;
        if (ln.name_idx != NameLen) ln.mismatch = 1'b1;
      end else if (!ln.mismatch) begin
        if (ln.name_idx < NameLen && c == hdr_char(ln.name_idx)) begin
          ln.name_idx = ln.name_idx + 1'b1;
        end else begin
          ln.mismatch = 1'b1;
        end
      end
    end else if (!ln.mismatch) begin
      value_char(c);
    end
  endfunction

  function automatic void track_byte(in_t it);
    out_t res;
    if (it.byte_in == ChLf && cr_seen) begin
      cr_seen = 1'b0;
      close_line();
    end else begin
      cr_seen = (it.byte_in == ChCr);
      if (!is_space(it.byte_in)) line_char(it.byte_in);
    end
    if (it.last_byte) begin
      close_line();
      res.found        = have_len;
      res.length_value = have_len ? len_val : '0;
      len_q.push_back(res);
      n_expected++;
      have_len = 1'b0;
      len_val  = '0;
      cr_seen  = 1'b0;
      ln       = LineReset;
    end
  endfunction

  // block construction
  function automatic byte unsigned ws_byte();
    int unsigned k;
    k = $urandom_range(5);
    return (k == 5) ? ChSpace : ChTab + k;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(7) == 0) blk.push_back(ws_byte());
      blk.push_back(s[i]);
    end
  endfunction

  function automatic void put_digits(int unsigned n);
    for (int i = 0; i < n; i++) begin
      blk.push_back(ChZero + $urandom_range(9));
    end
  endfunction

  function automatic void put_value();
    case ($urandom_range(5))
      0: blk.push_back(ChPlus);
      1: blk.push_back(ChMinus);
      2: if ($urandom_range(3) == 0) put_text("+-");
      default: ;
    endcase
    case ($urandom_range(11))
      0: put_text("18446744073709551615");
      1: put_text("18446744073709551616");
      2: put_digits($urandom_range(21, 24));
      3: ;
      4: put_digits($urandom_range(15, 20));
      default: put_digits($urandom_range(1, 6));
    endcase
    case ($urandom_range(7))
      0: put_text(":12");
      1: put_text("x9");
      2: blk.push_back($urandom_range(255));
      default: ;
    endcase
  endfunction

  function automatic void put_line();
    string nm;
    int unsigned k;
    nm = "Content-Length";
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        put_text(nm);
        blk.push_back(ChColon);
        put_value();
      end
      4: begin
        k = $urandom_range(NameLen - 1);
        if ($urandom_range(2) == 0) nm = nm.substr(0, k);
        else nm[k] = 8'h21 + $urandom_range(93);
        put_text(nm);
        blk.push_back(ChColon);
        put_value();
      end
      5: begin
        put_text("Content:-Length:");
        put_value();
      end
      6: begin
        put_text(nm);
        put_value();
      end
      7: begin
        for (int i = $urandom_range(6); i > 0; i--) blk.push_back($urandom_range(255));
      end
      default: ;
    endcase
  endfunction

  function automatic void put_sep();
    case ($urandom_range(9))
      0: blk.push_back(ChCr);
      1: blk.push_back(ChLf);
      2: begin
        blk.push_back(ChLf);
        blk.push_back(ChCr);
      end
      default: begin
        blk.push_back(ChCr);
        blk.push_back(ChLf);
      end
    endcase
  endfunction

  function automatic void flush_block();
    pend_t p;
    if (blk.size() == 0) blk.push_back($urandom_range(255));
    for (int i = 0; i < blk.size(); i++) begin
      p.pl.byte_in   = blk[i];
      p.pl.last_byte = (i == blk.size() - 1);
      p.drain        = 1'b0;
      p.rx_hold      = 1'b0;
      pend_q.push_back(p);
    end
    blk.delete();
  endfunction

  function automatic void rand_block(logic tiny);
    int unsigned nl;
    if (tiny || $urandom_range(9) < 3) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) blk.push_back($urandom_range(255));
    end else begin
      nl = $urandom_range(1, 3);
      for (int i = 0; i < nl; i++) begin
        put_line();
        if (i != nl - 1 || $urandom_range(1) == 0) put_sep();
      end
    end
    flush_block();
  endfunction

  initial begin
    int unsigned mark;
    bit          hold_done;
    bit          drain_done;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    blk.push_back(8'hFF);
    flush_block();
    blk.push_back(8'h00);
    flush_block();
    put_text("Content-Length:-1");
    flush_block();
    while (pend_q.size() < NumItems) begin
      if (!hold_done && pend_q.size() > 400) begin
        hold_done = 1'b1;
        mark = pend_q.size();
        for (int i = 0; i < 8; i++) rand_block(1'b1);
        pend_q[mark].rx_hold = 1'b1;
      end else if (!drain_done && pend_q.size() > 900) begin
        drain_done = 1'b1;
        mark = pend_q.size();
        rand_block(1'b0);
        pend_q[mark].drain = 1'b1;
      end else begin
        rand_block(1'b0);
      end
    end
    n_total = pend_q.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (n_sent != n_total || n_checked != n_expected) @(negedge clk_i);
    repeat (TailCyc) @(negedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // byte driver
  always @(posedge clk_i) begin
    logic tx_idle;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_hold_go <= 1'b0;
    end else begin
      tx_idle = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        track_byte(cur.pl);
        n_sent++;
      end
      rx_hold_go <= in_valid_i && !in_stall_o && cur.rx_hold;
      if (!in_valid_i || !in_stall_o) begin
        if (pend_q.size() != 0) begin
          tx_idle = (pend_q[0].drain && n_checked != n_expected) ||
                    (rx_hold_left == 0 && !quiet && $urandom_range(99) < 22);
        end
        if (pend_q.size() != 0 && !tx_idle) begin
          cur = pend_q.pop_front();
          in_valid_i <= 1'b1;
          in_i       <= cur.pl;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (rx_hold_go) begin
      rx_hold_left <= HoldCyc;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    out_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (len_q.size() == 0) begin
          $error("length transaction with no block pending");
          errors++;
        end else begin
          e = len_q.pop_front();
          if (out_o.found !== e.found) begin
            $error("found: expected %0d, got %0d", e.found, out_o.found);
            errors++;
          end
          if (out_o.length_value !== e.length_value) begin
            $error("length_value: expected %0d, got %0d", e.length_value, out_o.length_value);
            errors++;
          end
          n_checked <= n_checked + 1;
        end
      end
      out_stall_i <= (rx_hold_left != 0) || (!quiet && $urandom_range(99) < 22);
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CycLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
